### design/hhn_pkg.sv
// Shared types and constants for the HTTP header normalizer.
// Used by the channel interfaces, the lexer, the result FIFO, the top level and the checker.
package hhn_pkg;

    localparam int BYTE_W     = 8;
    localparam int MAX_RES    = 2;
    localparam int LEX_PASSES = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;

    typedef enum logic [3:0] {
        MODE_COPY = 4'b0001,
        MODE_CRLF = 4'b0010,
        MODE_FOLD = 4'b0100,
        MODE_BODY = 4'b1000
    } t_mode;

    typedef struct packed {
        t_mode             mode;
        logic [BYTE_W-1:0] prev;
        logic [BYTE_W-1:0] held;
        logic              held_valid;
    } t_lex_state;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              is_body;
        logic              header_end;
        logic              run_last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_lex_out;

endpackage

### design/hhn_in_if.sv
// Input channel interface carrying one received byte per transaction.
// Depends on hhn_pkg for the byte width.
interface hhn_in_if;
    logic                      valid;
    logic                      ready;
    logic [hhn_pkg::BYTE_W-1:0] in_byte;

    modport source(output valid, output in_byte, input ready);
    modport sink(input valid, input in_byte, output ready);
endinterface

### design/hhn_out_if.sv
// Output channel interface carrying one normalized byte and its flags per transaction.
// Depends on hhn_pkg for the byte width.
interface hhn_out_if;
    logic                      valid;
    logic                      ready;
    logic [hhn_pkg::BYTE_W-1:0] out_byte;
    logic                      is_body;
    logic                      header_end;
    logic                      run_last;

    modport source(output valid, output out_byte, output is_body, output header_end,
                   output run_last, input ready);
    modport sink(input valid, input out_byte, input is_body, input header_end,
                 input run_last, output ready);
endinterface

### design/hhn_lexer.sv
// Header lexer: state register and the per-byte rules that give up to two results.
// Depends on hhn_pkg for the state and result types.
module hhn_lexer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic [hhn_pkg::BYTE_W-1:0] i_byte,
    output hhn_pkg::t_lex_out          o_res
);

    hhn_pkg::t_lex_state r_state;
    hhn_pkg::t_lex_state n_state;
    hhn_pkg::t_result    v_res [hhn_pkg::MAX_RES];
    logic [1:0]          v_n;
    logic                v_done;
    logic                v_end;

    always_comb begin
        n_state  = r_state;
        v_n      = 2'd0;
        v_done   = 1'b0;
        v_end    = 1'b0;
        v_res[0] = '0;
        v_res[1] = '0;
        for (int p = 0; p < hhn_pkg::LEX_PASSES; p++) begin
            if (!v_done) begin
                case (n_state.mode)
                    hhn_pkg::MODE_BODY: begin
                        v_res[v_n[0]] = '{data: i_byte, is_body: 1'b1, header_end: 1'b0,
                                          run_last: 1'b0};
                        v_n    = v_n + 2'd1;
                        v_done = 1'b1;
                    end
                    hhn_pkg::MODE_CRLF: begin
                        if (n_state.prev == hhn_pkg::CH_LF) begin
                            n_state.mode = hhn_pkg::MODE_BODY;
                            if (n_state.held_valid) begin
                                v_res[v_n[0]] = '{data: n_state.held, is_body: 1'b0,
                                                  header_end: 1'b1, run_last: 1'b0};
                                v_n = v_n + 2'd1;
                            end
                            n_state.held_valid = 1'b0;
                        end else begin
                            n_state.mode = hhn_pkg::MODE_FOLD;
                            n_state.prev = hhn_pkg::CH_LF;
                        end
                        v_done = (i_byte == hhn_pkg::CH_LF);
                    end
                    hhn_pkg::MODE_FOLD: begin
                        n_state.mode = hhn_pkg::MODE_COPY;
                        if (i_byte == hhn_pkg::CH_SP || i_byte == hhn_pkg::CH_TAB) begin
                            n_state.held       = hhn_pkg::CH_SP;
                            n_state.held_valid = 1'b1;
                            n_state.prev       = hhn_pkg::CH_SP;
                            v_done             = 1'b1;
                        end
                    end
                    hhn_pkg::MODE_COPY: begin
                        v_end = 1'b0;
                        if (i_byte == hhn_pkg::CH_CR) begin
                            if (n_state.held_valid) begin
                                v_res[v_n[0]] = '{data: n_state.held, is_body: 1'b0,
                                                  header_end: 1'b0, run_last: 1'b0};
                                v_n = v_n + 2'd1;
                            end
                            n_state.held       = hhn_pkg::CH_LF;
                            n_state.held_valid = 1'b1;
                            n_state.mode       = hhn_pkg::MODE_CRLF;
                        end else begin
                            if (i_byte == hhn_pkg::CH_LF) begin
                                if (n_state.prev == hhn_pkg::CH_LF) begin
                                    n_state.mode = hhn_pkg::MODE_BODY;
                                    v_end        = 1'b1;
                                end else begin
                                    n_state.mode = hhn_pkg::MODE_FOLD;
                                end
                            end
                            if (n_state.held_valid) begin
                                v_res[v_n[0]] = '{data: n_state.held, is_body: 1'b0,
                                                  header_end: 1'b0, run_last: 1'b0};
                                v_n = v_n + 2'd1;
                            end
                            n_state.held       = i_byte;
                            n_state.held_valid = 1'b1;
                            n_state.prev       = i_byte;
                            if (v_end) begin
                                v_res[v_n[0]] = '{data: n_state.held, is_body: 1'b0,
                                                  header_end: 1'b1, run_last: 1'b0};
                                v_n                = v_n + 2'd1;
                                n_state.held_valid = 1'b0;
                            end
                        end
                        v_done = 1'b1;
                    end
                    default: begin
                        v_done = 1'b1;
                    end
                endcase
            end
        end
        if (v_n == 2'd1) begin
            v_res[0].run_last = 1'b1;
        end
        if (v_n == 2'd2) begin
            v_res[1].run_last = 1'b1;
        end
        o_res = '{count: v_n, res0: v_res[0], res1: v_res[1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: hhn_pkg::MODE_COPY, prev: '0, held: '0, held_valid: 1'b0};
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

endmodule

### design/hhn_out_fifo.sv
// Result FIFO: takes up to two results per cycle and presents one per output transaction.
// Depends on hhn_pkg for the result types and on hhn_out_if for the output channel.
module hhn_out_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  hhn_pkg::t_lex_out i_res,
    output logic              o_room,
    hhn_out_if.source         o_out
);

    hhn_pkg::t_result              r_mem [hhn_pkg::FIFO_DEPTH];
    logic [hhn_pkg::FIFO_AW-1:0]   r_rd_ptr;
    logic [hhn_pkg::FIFO_AW-1:0]   r_wr_ptr;
    logic [hhn_pkg::FIFO_CW-1:0]   r_count;
    logic [hhn_pkg::FIFO_CW-1:0]   n_count;
    logic [1:0]                    push_n;
    logic                          pop;
    hhn_pkg::t_result              head;

    assign push_n = i_push ? i_res.count : 2'd0;
    assign pop    = o_out.valid && o_out.ready;
    assign n_count = r_count + hhn_pkg::FIFO_CW'(push_n) - hhn_pkg::FIFO_CW'(pop);
    assign o_room = r_count <= hhn_pkg::FIFO_CW'(hhn_pkg::FIFO_DEPTH - hhn_pkg::MAX_RES);

    assign head             = r_mem[r_rd_ptr];
    assign o_out.valid      = r_count != '0;
    assign o_out.out_byte   = head.data;
    assign o_out.is_body    = head.is_body;
    assign o_out.header_end = head.header_end;
    assign o_out.run_last   = head.run_last;

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_res.res0;
        end
        if (push_n == 2'd2) begin
            r_mem[r_wr_ptr + hhn_pkg::FIFO_AW'(1)] <= i_res.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + hhn_pkg::FIFO_AW'(push_n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + hhn_pkg::FIFO_AW'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

### design/http_header_normalizer_core.sv
// HTTP header normalizer: takes one input byte per cycle while the FIFO has room; a result
// passes through an input register, the combinational lexer and a four-entry FIFO.
// A byte that gives two results is presented on the single-result output port as two
// transactions, and the FIFO absorbs that until it holds more than two results.
// Synchronous active-low reset returns the lexer to copy mode and empties all stages.
module http_header_normalizer_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hhn_in_if.sink    i_in,
    hhn_out_if.source o_out
);

    logic                       r_in_valid;
    logic [hhn_pkg::BYTE_W-1:0] r_in_byte;
    logic                       fire;
    logic                       room;
    hhn_pkg::t_lex_out          lex_res;

    assign fire       = r_in_valid && room;
    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    hhn_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .o_res   (lex_res)
    );

    hhn_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fire),
        .i_res   (lex_res),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

### design/hhn_checker.sv
// Port-level checker for the HTTP header normalizer and its bind to the top level.
// Depends on hhn_pkg for the newline constant and byte width.
module hhn_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [hhn_pkg::BYTE_W-1:0] i_out_byte,
    input logic                       i_is_body,
    input logic                       i_header_end
);

    logic r_body_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_seen <= 1'b0;
        end else if (i_out_valid && i_out_ready && i_is_body) begin
            r_body_seen <= 1'b1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("Output valid right after reset.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte))
        else $error("Stalled output transaction changed.");

    a_end_is_newline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_header_end |-> i_out_byte == hhn_pkg::CH_LF && !i_is_body)
        else $error("Header end flag on a byte that is not a header newline.");

    a_body_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_body_seen && i_out_valid |-> i_is_body && !i_header_end)
        else $error("Header byte after the body started.");

endmodule

bind http_header_normalizer_core hhn_checker u_hhn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.out_byte),
    .i_is_body    (o_out.is_body),
    .i_header_end (o_out.header_end)
);
